// ===== rtl/mchw_pkg.sv =====
// Shared types and constants for the multi-channel heartbeat watchdog.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package mchw_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int TIMER_BITS_DEF   = 16;

    localparam int FUNC_W     = 2;
    localparam int CHAN_W     = 3;
    localparam int INTERVAL_W = 16;
    localparam int NSTAT_W    = 2;
    localparam int STATUS_W   = 3;
    localparam int PERIOD_W   = 16;

    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd30;

    localparam logic [STATUS_W-1:0] STAT_INIT    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_STALLED = 3'd4;

    typedef enum logic [FUNC_W-1:0] {
        FN_REGISTER   = 2'd0,
        FN_HEARTBEAT  = 2'd1,
        FN_SET_STATUS = 2'd2,
        FN_TICK       = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PUB
    } t_state;

    // Command broadcast from the controller to every channel cell.
    typedef struct packed {
        logic                  valid;
        t_func                 func;
        logic [INTERVAL_W-1:0] max_interval;
        logic [NSTAT_W-1:0]    new_status;
        logic                  load;
        logic                  shift;
    } t_cell_cmd;

    // One stage of the publication shift chain.
    typedef struct packed {
        logic                vld;
        logic [CHAN_W-1:0]   chan;
        logic [STATUS_W-1:0] status;
    } t_slot;

endpackage

`default_nettype wire

// ===== rtl/mchw_if.sv =====
// Channel interfaces of the heartbeat watchdog: item input, result output, configuration.
// Depends on mchw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mchw_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [mchw_pkg::FUNC_W-1:0]          func;
    logic [mchw_pkg::CHAN_W-1:0]          channel;
    logic [mchw_pkg::INTERVAL_W-1:0]      max_interval;
    logic [mchw_pkg::NSTAT_W-1:0]         new_status;

    modport source (output valid, func, channel, max_interval, new_status, input ready);
    modport sink   (input valid, func, channel, max_interval, new_status, output ready);
endinterface

interface mchw_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [mchw_pkg::CHAN_W-1:0]          out_channel;
    logic [mchw_pkg::STATUS_W-1:0]        channel_status;
    logic                                 last;

    modport source (output valid, out_channel, channel_status, last, input ready);
    modport sink   (input valid, out_channel, channel_status, last, output ready);
endinterface

interface mchw_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [mchw_pkg::PERIOD_W-1:0]        data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/multi_channel_heartbeat_watchdog_top.sv =====
// Register, heartbeat and set-status beats take effect at the edge at which they are taken; a tick
// passes through the decision state and, when it publishes, through the publication state,
// which waits on output stalls. No new beat is taken until a tick is through; the shift chain
// carries one channel per cycle out of the row of cells while the sink is ready.
// Reset (synchronous, active low) clears enrolment, counters, status, the changed flag
// and the publish timer, and loads the publish period with 30 ticks.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_heartbeat_watchdog_top #(
    parameter int NUM_CHANNELS = mchw_pkg::NUM_CHANNELS_DEF,
    parameter int TIMER_BITS   = mchw_pkg::TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mchw_in_if.sink     i_in,
    mchw_out_if.source  o_out,
    mchw_cfg_if.sink    i_cfg
);

    // Width of the enrolled-channel count, which must be able to hold NUM_CHANNELS.
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
    // The publish timer and the period are compared at the wider of the two widths.
    localparam int PW    = (TIMER_BITS > mchw_pkg::PERIOD_W) ? TIMER_BITS
                                                            : mchw_pkg::PERIOD_W;

    mchw_pkg::t_state                  r_state, n_state;
    logic [mchw_pkg::PERIOD_W-1:0]     r_period, n_period;
    logic [TIMER_BITS-1:0]             r_pub_cnt, n_pub_cnt;
    logic                              r_changed, n_changed;
    logic [CNT_W-1:0]                  r_enr_cnt, n_enr_cnt;
    logic [CNT_W-1:0]                  r_left, n_left;

    mchw_pkg::t_cell_cmd               w_cmd;
    mchw_pkg::t_slot                   w_chain [NUM_CHANNELS+1];
    mchw_pkg::t_slot                   w_head;
    logic [NUM_CHANNELS-1:0]           w_sel;
    logic [NUM_CHANNELS-1:0]           w_enr;
    logic [NUM_CHANNELS-1:0]           w_flag;
    logic                              w_accept;
    logic                              w_is_tick;
    logic                              w_new_enrol;
    logic                              w_any_flag;
    logic                              w_publish;
    logic [TIMER_BITS-1:0]             w_pub_inc;

    // A beat is taken only between ticks; each item other than a tick is fully applied when taken,
    // and a tick is then judged and possibly published.
    assign i_in.ready  = (r_state == mchw_pkg::ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_is_tick   = (mchw_pkg::t_func'(i_in.func) == mchw_pkg::FN_TICK);

    // The config register is always writable; the user must write it only while idle, unenforced.
    assign i_cfg.ready = 1'b1;

    // One-hot channel select. Channels at or above NUM_CHANNELS match no cell, so such
    // beats, other than ticks, fall away without effect.
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_sel
        assign w_sel[g] = (32'(i_in.channel) == g);
    end

    // A register beat for a channel that is not yet enrolled grows the enrolled count.
    assign w_new_enrol = w_accept &&
                         (mchw_pkg::t_func'(i_in.func) == mchw_pkg::FN_REGISTER) &&
                         (|(w_sel & ~w_enr));

    // Each cell raises a registered flag in the cycle after a status change or a stall.
    assign w_any_flag = |w_flag;

    assign w_pub_inc = (r_pub_cnt == {TIMER_BITS{1'b1}}) ? r_pub_cnt
                                                         : r_pub_cnt + TIMER_BITS'(1);

    // The table is published if it changed (including stalls found on this tick) or
    // the timer has reached the period, but only once any channel is enrolled.
    assign w_publish = (r_enr_cnt != '0) &&
                       (r_changed || w_any_flag || (PW'(r_pub_cnt) >= PW'(r_period)));

    assign w_head = w_chain[0];

    always_comb begin
        w_cmd.valid        = w_accept;
        w_cmd.func         = mchw_pkg::t_func'(i_in.func);
        w_cmd.max_interval = i_in.max_interval;
        w_cmd.new_status   = i_in.new_status;
        w_cmd.load         = (r_state == mchw_pkg::ST_DECIDE) && w_publish;
        // Empty slots are skipped at once; a full slot moves on when the sink takes it.
        w_cmd.shift        = (r_state == mchw_pkg::ST_PUB) && (!w_head.vld || o_out.ready);
    end

    // The row of channel cells. Cell 0 sits at the output end of the shift chain and the
    // stage beyond the last cell feeds empty slots in.
    assign w_chain[NUM_CHANNELS] = '0;

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
        mchw_cell #(
            .TIMER_BITS (TIMER_BITS),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_sel      (w_sel[g]),
            .i_slot     (w_chain[g+1]),
            .o_slot     (w_chain[g]),
            .o_enrolled (w_enr[g]),
            .o_flag     (w_flag[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_period  = r_period;
        n_pub_cnt = r_pub_cnt;
        n_changed = r_changed || w_any_flag;
        n_enr_cnt = r_enr_cnt;
        n_left    = r_left;

        if (i_cfg.valid && i_cfg.ready) begin
            n_period = i_cfg.data;
        end
        if (w_new_enrol) begin
            n_enr_cnt = r_enr_cnt + CNT_W'(1);
        end

        case (r_state)
            mchw_pkg::ST_IDLE: begin
                if (w_accept && w_is_tick) begin
                    n_pub_cnt = w_pub_inc;
                    n_state   = mchw_pkg::ST_DECIDE;
                end
            end
            mchw_pkg::ST_DECIDE: begin
                // When publishing, the cells load their slots at this edge; the stall
                // flags of the tick are folded in here and cleared together with the timer.
                if (w_publish) begin
                    n_changed = 1'b0;
                    n_pub_cnt = '0;
                    n_left    = r_enr_cnt;
                    n_state   = mchw_pkg::ST_PUB;
                end else begin
                    n_state   = mchw_pkg::ST_IDLE;
                end
            end
            mchw_pkg::ST_PUB: begin
                if (w_head.vld && o_out.ready) begin
                    n_left = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = mchw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = mchw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mchw_pkg::ST_IDLE;
            r_period  <= mchw_pkg::RESET_PERIOD;
            r_pub_cnt <= '0;
            r_changed <= 1'b0;
            r_enr_cnt <= '0;
            r_left    <= '0;
        end else begin
            r_state   <= n_state;
            r_period  <= n_period;
            r_pub_cnt <= n_pub_cnt;
            r_changed <= n_changed;
            r_enr_cnt <= n_enr_cnt;
            r_left    <= n_left;
        end
    end

    // The result beat comes straight from the register at the head of the chain; the
    // last beat of a publication is the one that empties the count of channels left to send.
    assign o_out.valid          = (r_state == mchw_pkg::ST_PUB) && w_head.vld;
    assign o_out.out_channel    = w_head.chan;
    assign o_out.channel_status = w_head.status;
    assign o_out.last           = (r_left == CNT_W'(1));

`ifndef SYNTH
    a_out_only_pub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_state == mchw_pkg::ST_PUB))
        else $error("result beat outside a publication");

    a_pub_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mchw_pkg::ST_PUB) |-> (r_left != '0))
        else $error("publication running with nothing left to send");

    a_enr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_enr_cnt) <= NUM_CHANNELS) && (32'(r_enr_cnt) == $countones(w_enr)))
        else $error("enrolled count disagrees with the cells");

    a_tick_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_tick) |=> (r_state == mchw_pkg::ST_DECIDE))
        else $error("tick not followed by the decision cycle");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> (r_state == mchw_pkg::ST_IDLE))
        else $error("publication did not end after its last beat");
`endif

endmodule

`default_nettype wire

// ===== rtl/mchw_cell.sv =====
// One channel cell of the watchdog: enrolment, timeout, elapsed counter, status
// and one stage of the publication shift chain. Depends on mchw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mchw_cell #(
    parameter int TIMER_BITS = mchw_pkg::TIMER_BITS_DEF,
    parameter int IDX        = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mchw_pkg::t_cell_cmd i_cmd,
    input  logic                i_sel,
    input  mchw_pkg::t_slot     i_slot,
    output mchw_pkg::t_slot     o_slot,
    output logic                o_enrolled,
    output logic                o_flag
);

    localparam int CMP_W = (TIMER_BITS > mchw_pkg::INTERVAL_W) ? TIMER_BITS
                                                              : mchw_pkg::INTERVAL_W;

    logic                              r_enr, n_enr;
    logic [mchw_pkg::INTERVAL_W-1:0]   r_timeout, n_timeout;
    logic [TIMER_BITS-1:0]             r_elapsed, n_elapsed;
    logic [mchw_pkg::STATUS_W-1:0]     r_status, n_status;
    logic                              r_flag, n_flag;
    mchw_pkg::t_slot                   r_slot, n_slot;

    logic [TIMER_BITS-1:0]             w_inc;
    logic                              w_stall;

    assign w_inc   = (r_elapsed == {TIMER_BITS{1'b1}}) ? r_elapsed
                                                       : r_elapsed + TIMER_BITS'(1);
    assign w_stall = r_enr && (CMP_W'(w_inc) > CMP_W'(r_timeout));

    always_comb begin
        n_enr     = r_enr;
        n_timeout = r_timeout;
        n_elapsed = r_elapsed;
        n_status  = r_status;
        n_flag    = 1'b0;
        if (i_cmd.valid) begin
            if (i_cmd.func == mchw_pkg::FN_TICK) begin
                n_elapsed = w_inc;
                if (w_stall) begin
                    n_status = mchw_pkg::STAT_STALLED;
                    n_flag   = 1'b1;
                end
            end else if (i_sel) begin
                case (i_cmd.func)
                    mchw_pkg::FN_REGISTER: begin
                        if (!r_enr) begin
                            n_enr    = 1'b1;
                            n_status = mchw_pkg::STAT_INIT;
                        end
                        n_timeout = i_cmd.max_interval;
                        n_elapsed = '0;
                    end
                    mchw_pkg::FN_HEARTBEAT: begin
                        if (r_enr) begin
                            n_elapsed = '0;
                        end
                    end
                    mchw_pkg::FN_SET_STATUS: begin
                        if (r_enr) begin
                            n_flag    = (r_status != {1'b0, i_cmd.new_status});
                            n_status  = {1'b0, i_cmd.new_status};
                            n_elapsed = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // The chain moves towards cell 0, so results leave in ascending channel order.
    always_comb begin
        n_slot = r_slot;
        if (i_cmd.load) begin
            n_slot.vld    = r_enr;
            n_slot.chan   = mchw_pkg::CHAN_W'(IDX);
            n_slot.status = r_status;
        end else if (i_cmd.shift) begin
            n_slot = i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enr     <= 1'b0;
            r_elapsed <= '0;
            r_status  <= mchw_pkg::STAT_INIT;
            r_flag    <= 1'b0;
            r_slot    <= '0;
        end else begin
            r_enr     <= n_enr;
            r_elapsed <= n_elapsed;
            r_status  <= n_status;
            r_flag    <= n_flag;
            r_slot    <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_timeout <= n_timeout;
    end

    assign o_slot     = r_slot;
    assign o_enrolled = r_enr;
    assign o_flag     = r_flag;

endmodule

`default_nettype wire
